// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that the property holds at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/trs_pkg.sv =====
`timescale 1ns / 1ps
package trs_pkg;

  localparam int FracBitsDefault    = 16;
  localparam int CordicStepsDefault = 16;
  localparam int AtanEntries        = 30;

  localparam logic signed [33:0] Deg2RadQ32   = 34'sd74961321;
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] angle_x;
    logic signed [31:0] angle_y;
    logic signed [31:0] angle_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
  } trs_in_t;

  typedef struct packed {
    logic signed [31:0] row0_col0;
    logic signed [31:0] row0_col1;
    logic signed [31:0] row0_col2;
    logic signed [31:0] row0_col3;
    logic signed [31:0] row1_col0;
    logic signed [31:0] row1_col1;
    logic signed [31:0] row1_col2;
    logic signed [31:0] row1_col3;
    logic signed [31:0] row2_col0;
    logic signed [31:0] row2_col1;
    logic signed [31:0] row2_col2;
    logic signed [31:0] row2_col3;
  } trs_out_t;

  // Sine/cosine pair in Q2.30 with a few bits of headroom.
  typedef struct packed {
    logic signed [33:0] c;
    logic signed [33:0] s;
  } trs_sc_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.30 product rounded half up: (a*b + 2^29) >>> 30.
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction

  // Q2.30 entry times Q.F scale, rounded, then saturated to 32 bits.
  function automatic logic signed [31:0] scale_sat(input logic signed [33:0] r,
                                                   input logic signed [31:0] s);
    logic signed [65:0] p;
    logic signed [35:0] q;
    p = r * s + 66'sd536870912;
    q = p[65:30];
    if (q > 36'sd2147483647) return 32'sh7FFFFFFF;
    else if (q < -36'sd2147483648) return 32'sh80000000;
    else return q[31:0];
  endfunction

endpackage

// ===== rtl/core/trs_model_matrix.sv =====
`timescale 1ns / 1ps
// trs_model_matrix: model matrix T*Rx*Ry*Rz*S from position, Euler angles
// (degrees) and scale, all signed fixed point with FRAC_BITS fraction bits.
//
// Channels: in_valid/in_ready carry one trs_in_t transaction, out_valid/
// out_ready one trs_out_t transaction (upper three rows, translation in
// column 3). One result per input transaction, in order.
//
// Throughput: one transaction per cycle while out_ready does not stall it.
// From acceptance to out_valid a transaction passes angle reduction (two
// stages), radian conversion, the chain of CORDIC cells (one step per
// cell, CORDIC_STEPS capped at 30) and three product stages, the last of
// which is the output register.
//
// The pipeline moves as one: every stage advances when the output register
// is empty or being drained, so a stall at the receiver holds every stage
// and lowers in_ready in the same cycle, and no transaction is dropped.
//
// Reset clears all valid bits; payload registers are not reset.
module trs_model_matrix #(
  parameter int FRAC_BITS    = trs_pkg::FracBitsDefault,
  parameter int CORDIC_STEPS = trs_pkg::CordicStepsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trs_pkg::trs_in_t  in,
  output logic              out_valid,
  input  logic              out_ready,
  output trs_pkg::trs_out_t out
);

  `include "assert_macros.svh"

  localparam int Steps = (CORDIC_STEPS > trs_pkg::AtanEntries) ?
                         trs_pkg::AtanEntries : CORDIC_STEPS;
  // stage count: reduce(2) + rad(1) + cordic(Steps) + products(3), the last
  // product stage being the output register
  localparam int Depth = Steps + 6;

  logic [Depth-1:0] vld;
  logic             adv;

  assign adv      = !vld[Depth-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  // Side data (position, scale) travels beside the angle path.
  logic signed [31:0] side [Depth-1][6];
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0][0] <= in.pos_x;   side[0][1] <= in.pos_y;   side[0][2] <= in.pos_z;
      side[0][3] <= in.scale_x; side[0][4] <= in.scale_y; side[0][5] <= in.scale_z;
      for (int s = 1; s < Depth - 1; s++) side[s] <= side[s-1];
    end
  end

  // Stages 0 and 1: modulo 360, fold to [-90, 90].
  localparam logic signed [41:0] Full    = 42'sd360 <<< FRAC_BITS;
  localparam logic signed [41:0] Half    = 42'sd180 <<< FRAC_BITS;
  localparam logic signed [41:0] Quarter = 42'sd90 <<< FRAC_BITS;
  // floor(2^40 / Full): quotient estimate off by at most one
  localparam logic signed [25:0] Recip   = 26'((64'sd1 <<< 40) / 64'(Full));

  logic signed [31:0] ang [3];
  assign ang[0] = in.angle_x;
  assign ang[1] = in.angle_y;
  assign ang[2] = in.angle_z;

  logic signed [31:0] ang_d [3];
  logic signed [17:0] quo [3];
  logic signed [31:0] red1 [3];
  logic [2:0] neg1;
  logic [2:0] neg2;
  logic signed [33:0] zr [3];

  // Estimate the turn count by reciprocal multiplication; hold the angle.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [57:0] p;
        p = ang[k] * Recip;
        quo[k]   <= 18'(p >>> 40);
        ang_d[k] <= ang[k];
      end
    end
  end

  // Remove the turns, correct the estimate by one turn, then fold.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [41:0] r;
        logic n;
        r = 42'(ang_d[k]) - 42'(quo[k]) * Full;
        n = 1'b0;
        if (r < 0) r = r + Full;
        else if (r >= Full) r = r - Full;
        if (r >= Half) begin
          r = r - Half;
          n = !n;
        end
        if (r > Quarter) begin
          r = r - Half;
          n = !n;
        end
        red1[k] <= 32'(r);
        neg1[k] <= n;
      end
    end
  end

  // Stage 2: degrees to radians in Q2.30.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [75:0] p;
        p = red1[k] * trs_pkg::Deg2RadQ32 + (76'sd1 <<< (FRAC_BITS + 1));
        zr[k] <= 34'(p >>> (FRAC_BITS + 2));
      end
      neg2 <= neg1;
    end
  end

  // CORDIC chain of cells.
  logic signed [33:0] cx [Steps+1][3];
  logic signed [33:0] cy [Steps+1][3];
  logic signed [33:0] cz [Steps+1][3];
  logic [2:0] negc [Steps+1];

  for (genvar k = 0; k < 3; k++) begin : g_init
    assign cx[0][k] = trs_pkg::CordicGainQ30;
    assign cy[0][k] = '0;
    assign cz[0][k] = zr[k];
  end
  assign negc[0] = neg2;

  for (genvar i = 0; i < Steps; i++) begin : g_cell
    trs_cordic_cell #(.Step(i)) u_cell (
      .clk  (clk),
      .en   (adv),
      .x_in (cx[i]),
      .y_in (cy[i]),
      .z_in (cz[i]),
      .x    (cx[i+1]),
      .y    (cy[i+1]),
      .z    (cz[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) negc[i+1] <= negc[i];
    end
  end

  // Product stage A: sign fix and two-factor products.
  trs_pkg::trs_sc_t sc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sc[k].c = negc[Steps][k] ? -cx[Steps][k] : cx[Steps][k];
      sc[k].s = negc[Steps][k] ? -cy[Steps][k] : cy[Steps][k];
    end
  end

  logic signed [33:0] a_cycz, a_cysz, a_sy, a_sxsy, a_cxsz, a_cxcz, a_sxcy;
  logic signed [33:0] a_cxsy, a_sxsz, a_sxcz, a_cxcy, a_cz, a_sz;
  always_ff @(posedge clk) begin
    if (adv) begin
      a_cycz <= trs_pkg::mul_q30(sc[1].c, sc[2].c);
      a_cysz <= trs_pkg::mul_q30(sc[1].c, sc[2].s);
      a_sy   <= sc[1].s;
      a_sxsy <= trs_pkg::mul_q30(sc[0].s, sc[1].s);
      a_cxsz <= trs_pkg::mul_q30(sc[0].c, sc[2].s);
      a_cxcz <= trs_pkg::mul_q30(sc[0].c, sc[2].c);
      a_sxcy <= trs_pkg::mul_q30(sc[0].s, sc[1].c);
      a_cxsy <= trs_pkg::mul_q30(sc[0].c, sc[1].s);
      a_sxsz <= trs_pkg::mul_q30(sc[0].s, sc[2].s);
      a_sxcz <= trs_pkg::mul_q30(sc[0].s, sc[2].c);
      a_cxcy <= trs_pkg::mul_q30(sc[0].c, sc[1].c);
      a_cz   <= sc[2].c;
      a_sz   <= sc[2].s;
    end
  end

  // Product stage B: three-factor terms and rotation entries.
  logic signed [33:0] rot [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      rot[0] <= a_cycz;
      rot[1] <= -a_cysz;
      rot[2] <= a_sy;
      rot[3] <= trs_pkg::mul_q30(a_sxsy, a_cz) + a_cxsz;
      rot[4] <= -trs_pkg::mul_q30(a_sxsy, a_sz) + a_cxcz;
      rot[5] <= -a_sxcy;
      rot[6] <= -trs_pkg::mul_q30(a_cxsy, a_cz) + a_sxsz;
      rot[7] <= trs_pkg::mul_q30(a_cxsy, a_sz) + a_sxcz;
      rot[8] <= a_cxcy;
    end
  end

  // Product stage C: scale columns, saturate; this is the output register.
  localparam int SideIdx = Depth - 1;
  trs_pkg::trs_out_t res;
  always_ff @(posedge clk) begin
    if (adv) begin
      res.row0_col0 <= trs_pkg::scale_sat(rot[0], side[SideIdx-1][3]);
      res.row0_col1 <= trs_pkg::scale_sat(rot[1], side[SideIdx-1][4]);
      res.row0_col2 <= trs_pkg::scale_sat(rot[2], side[SideIdx-1][5]);
      res.row0_col3 <= side[SideIdx-1][0];
      res.row1_col0 <= trs_pkg::scale_sat(rot[3], side[SideIdx-1][3]);
      res.row1_col1 <= trs_pkg::scale_sat(rot[4], side[SideIdx-1][4]);
      res.row1_col2 <= trs_pkg::scale_sat(rot[5], side[SideIdx-1][5]);
      res.row1_col3 <= side[SideIdx-1][1];
      res.row2_col0 <= trs_pkg::scale_sat(rot[6], side[SideIdx-1][3]);
      res.row2_col1 <= trs_pkg::scale_sat(rot[7], side[SideIdx-1][4]);
      res.row2_col2 <= trs_pkg::scale_sat(rot[8], side[SideIdx-1][5]);
      res.row2_col3 <= side[SideIdx-1][2];
    end
  end
  assign out = res;

  `ASSERT_CLK(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out),
              "result changed while stalled")
  `ASSERT_CLK(a_ready_follows, clk, rst, !out_valid |-> in_ready,
              "input blocked with empty output")
  `ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !out_valid,
                 "valid after reset")

endmodule

// ===== rtl/core/trs_cordic_cell.sv =====
`timescale 1ns / 1ps
// One CORDIC rotation step for the three angles; registered, with enable.
module trs_cordic_cell #(
  parameter int Step = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [33:0]  x_in [3],
  input  logic signed [33:0]  y_in [3],
  input  logic signed [33:0]  z_in [3],
  output logic signed [33:0]  x [3],
  output logic signed [33:0]  y [3],
  output logic signed [33:0]  z [3]
);

  localparam logic [4:0] Idx = 5'(Step);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if (z_in[k] >= 0) begin
          x[k] <= x_in[k] - (y_in[k] >>> Step);
          y[k] <= y_in[k] + (x_in[k] >>> Step);
          z[k] <= z_in[k] - trs_pkg::atan_q30(Idx);
        end else begin
          x[k] <= x_in[k] + (y_in[k] >>> Step);
          y[k] <= y_in[k] - (x_in[k] >>> Step);
          z[k] <= z_in[k] + trs_pkg::atan_q30(Idx);
        end
      end
    end
  end

endmodule
